@@ rtl/core/mmtr_pkg.sv @@
// Shared types and constants for the Mueller-Muller timing recovery unit.
// No dependencies; compile before every other file of the block.
`default_nettype none

package mmtr_pkg;

    // Default values for the top-level parameters
    localparam int DEF_INTERP_FACTOR = 16;
    localparam int DEF_SAMPLE_BITS   = 16;

    // Fixed field widths
    localparam int CNT_W   = 32;
    localparam int SPS_W   = 7;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 19;
    localparam int PHASE_W = 16;
    localparam int SYM_W   = 16;

    // Error saturation limits (19-bit signed)
    localparam int ERR_MAX = 262143;
    localparam int ERR_MIN = -262144;

    // Configuration registers
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SPS  = 1'b0;
    localparam logic REG_GAIN = 1'b1;
    localparam logic [SPS_W-1:0]  SPS_RESET  = 7'd8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19661;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL,
        ST_PHASE,
        ST_TGT
    } mmtr_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // accept an input beat, count its position
        logic calc_err;   // form rails and the timing error
        logic calc_mul;   // scale the error by the loop gain
        logic calc_phase; // advance the phase, shift the history
        logic finish;     // compute the next target, load the result
    } mmtr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic hit;        // position count equals target
        logic out_free;   // result register can take a beat
    } mmtr_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/mmtr_if.sv @@
// Valid/ready stream interfaces for the sample input and the symbol output.
// Depends on mmtr_pkg.
`default_nettype none

interface mmtr_in_if #(
    parameter int SAMPLE_BITS = mmtr_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface mmtr_out_if;
    import mmtr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SYM_W-1:0]   symbol_re;
    logic signed [SYM_W-1:0]   symbol_im;
    logic signed [ERR_W-1:0]   timing_error;
    logic        [PHASE_W-1:0] phase_frac;

    modport source (output valid, output symbol_re, output symbol_im,
                    output timing_error, output phase_frac, input ready);
    modport sink   (input valid, input symbol_re, input symbol_im,
                    input timing_error, input phase_frac, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mueller_muller_timing_recovery_unit.sv @@
// Mueller-Muller symbol timing recovery on an interpolated complex sample
// stream. Every accepted sample advances a 32-bit position counter; a sample
// whose position equals the current target is taken as a symbol and yields
// one result beat (symbol, timing error, updated fractional phase), all other
// samples yield nothing. A sample that is not a symbol is only counted; a
// symbol sample steps through accept, error, gain multiply, phase update
// and target update, the controller stepping the shared loop datapath once
// per stage, and the target update waits while a stalled output holds the
// result register. Only one result is held; the next sample is accepted while
// it waits. Configuration sits on an APB port: samples_per_symbol at byte 0,
// loop_gain at byte 4 (address bit 2 selects); write it only while idle.
// Depends on mmtr_pkg, mmtr_if, mmtr_ctrl and mmtr_dp.
`default_nettype none

module mueller_muller_timing_recovery_unit #(
    parameter int INTERP_FACTOR = mmtr_pkg::DEF_INTERP_FACTOR,
    parameter int SAMPLE_BITS   = mmtr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mmtr_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [mmtr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [mmtr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready,
    mmtr_in_if.sink                                   in_ch,
    mmtr_out_if.source                                out_ch
);
    import mmtr_pkg::*;

    logic [SPS_W-1:0]  sps_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              cfg_wr;

    mmtr_cmd_t cmd;
    mmtr_sts_t sts;

    // Configuration registers: write on the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg  <= SPS_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_SPS:  sps_reg  <= pwdata[SPS_W-1:0];
                REG_GAIN: gain_reg <= pwdata[GAIN_W-1:0];
                default:  sps_reg  <= sps_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SPS:  prdata = APB_DATA_W'(sps_reg);
            REG_GAIN: prdata = APB_DATA_W'(gain_reg);
            default:  prdata = '0;
        endcase
    end

    // Sequencer: one state per loop stage of a symbol
    mmtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Counters, error detector, loop filter and result register
    mmtr_dp #(
        .INTERP_FACTOR (INTERP_FACTOR),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sps          (sps_reg),
        .gain         (gain_reg),
        .sample_re    (in_ch.sample_re),
        .sample_im    (in_ch.sample_im),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .symbol_re    (out_ch.symbol_re),
        .symbol_im    (out_ch.symbol_im),
        .timing_error (out_ch.timing_error),
        .phase_frac   (out_ch.phase_frac)
    );

    // A new result beat only appears after the finish step
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.finish))
        else $error("result beat raised without a finish step");

    // A symbol sample starts the error step in the following cycle
    a_hit_starts_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && sts.hit) |=> cmd.calc_err)
        else $error("symbol sample did not start the loop update");

    // A plain sample leaves the block ready for the next beat
    a_miss_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && !sts.hit) |=> in_ch.ready)
        else $error("non-symbol sample stalled the input");

    // At most one datapath step per cycle
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.calc_err, cmd.calc_mul, cmd.calc_phase, cmd.finish}))
        else $error("more than one datapath command active");

endmodule

`default_nettype wire

@@ rtl/core/mmtr_ctrl.sv @@
// Sequencing state machine for the timing recovery unit.
// Depends on mmtr_pkg; drives the command struct of mmtr_dp.
`default_nettype none

module mmtr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mmtr_pkg::mmtr_sts_t sts,
    output mmtr_pkg::mmtr_cmd_t     cmd
);
    import mmtr_pkg::*;

    mmtr_state_t state_reg;
    mmtr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.hit)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_PHASE;
            ST_PHASE: state_next = ST_TGT;
            ST_TGT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_ERR:   cmd.calc_err   = 1'b1;
            ST_MUL:   cmd.calc_mul   = 1'b1;
            ST_PHASE: cmd.calc_phase = 1'b1;
            ST_TGT:   cmd.finish     = sts.out_free;
            default:  cmd            = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/mmtr_dp.sv @@
// Datapath: position counter, error, loop filter, phase and target registers.
// Depends on mmtr_pkg; sequenced by mmtr_ctrl.
`default_nettype none

module mmtr_dp #(
    parameter int INTERP_FACTOR = mmtr_pkg::DEF_INTERP_FACTOR,
    parameter int SAMPLE_BITS   = mmtr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mmtr_pkg::mmtr_cmd_t                 cmd,
    output mmtr_pkg::mmtr_sts_t                      sts,
    input  wire logic        [mmtr_pkg::SPS_W-1:0]   sps,
    input  wire logic        [mmtr_pkg::GAIN_W-1:0]  gain,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_im,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [mmtr_pkg::SYM_W-1:0]   symbol_re,
    output logic signed      [mmtr_pkg::SYM_W-1:0]   symbol_im,
    output logic signed      [mmtr_pkg::ERR_W-1:0]   timing_error,
    output logic             [mmtr_pkg::PHASE_W-1:0] phase_frac
);
    import mmtr_pkg::*;

    localparam int EXT   = (SAMPLE_BITS + 3 > ERR_W) ? SAMPLE_BITS + 3 : ERR_W;
    localparam int SW    = (SAMPLE_BITS > SYM_W) ? SAMPLE_BITS : SYM_W;
    localparam int PW    = GAIN_W + 1 + ERR_W;       // gain * error product
    localparam int SHW   = PW - 14;                  // product after >>> 14
    localparam int TW    = SHW + 4;                  // phase total
    localparam int FW    = PHASE_W + $clog2(INTERP_FACTOR + 1);
    localparam int STEPW = TW - PHASE_W;

    localparam logic signed [EXT-1:0] E_HI = EXT'(ERR_MAX);
    localparam logic signed [EXT-1:0] E_LO = EXT'(ERR_MIN);
    localparam logic signed [TW-1:0]  ONE_SAMPLE = TW'(65536);

    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   tgt_reg, tgt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;

    logic signed [SAMPLE_BITS-1:0] smp_re_reg, smp_im_reg;
    logic signed [SAMPLE_BITS-1:0] h0_re_reg, h0_im_reg, h1_re_reg, h1_im_reg;
    logic [1:0]                    rail0_reg, rail1_reg;
    logic signed [ERR_W-1:0]       err_reg, err_next;
    logic signed [PW-1:0]          prod_reg, prod_next;

    logic                          out_valid_reg;
    logic signed [SYM_W-1:0]       sym_re_reg, sym_im_reg;
    logic signed [ERR_W-1:0]       oerr_reg;
    logic [PHASE_W-1:0]            ophase_reg;

    logic [1:0]           rail_cur;
    logic signed [EXT-1:0] x_re, x_im, y_re, y_im, e_full;
    logic signed [TW-1:0]  total_raw, total;
    logic [STEPW-1:0]      step;
    logic [FW-1:0]         frac_prod;
    logic signed [SW-1:0]  ext_re, ext_im;

    assign sts.hit      = (pos_reg == tgt_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Sign rails of the current symbol: 1 when strictly positive
    assign rail_cur[0] = !smp_re_reg[SAMPLE_BITS-1] && (|smp_re_reg);
    assign rail_cur[1] = !smp_im_reg[SAMPLE_BITS-1] && (|smp_im_reg);

    // Mueller-Muller error: rail differences only take -1, 0 or +1
    always_comb
    begin
        case ({rail_cur[0], rail1_reg[0]})
            2'b10:   x_re = EXT'(h0_re_reg);
            2'b01:   x_re = -EXT'(h0_re_reg);
            default: x_re = '0;
        endcase
        case ({rail_cur[1], rail1_reg[1]})
            2'b10:   x_im = EXT'(h0_im_reg);
            2'b01:   x_im = -EXT'(h0_im_reg);
            default: x_im = '0;
        endcase
        y_re = rail0_reg[0] ? EXT'(smp_re_reg) - EXT'(h1_re_reg) : '0;
        y_im = rail0_reg[1] ? EXT'(smp_im_reg) - EXT'(h1_im_reg) : '0;
        e_full = y_re + y_im - x_re - x_im;
        if (e_full > E_HI)
        begin
            err_next = ERR_W'(E_HI);
        end
        else if (e_full < E_LO)
        begin
            err_next = ERR_W'(E_LO);
        end
        else
        begin
            err_next = ERR_W'(e_full);
        end
    end

    assign prod_next = $signed({1'b0, gain}) * err_reg;

    // Phase total in Q16 samples; arithmetic shift floors the gain term
    always_comb
    begin
        total_raw = TW'($signed({1'b0, phase_reg}))
                  + TW'($signed({1'b0, sps, 16'b0}))
                  + TW'($signed(prod_reg[PW-1:14]));
        total = (total_raw < ONE_SAMPLE) ? ONE_SAMPLE : total_raw;
        step  = total[TW-1:PHASE_W];
    end

    assign frac_prod = FW'(phase_reg) * FW'(INTERP_FACTOR);
    assign ext_re    = SW'(smp_re_reg);
    assign ext_im    = SW'(smp_im_reg);

    always_comb
    begin
        pos_next   = cmd.take ? pos_reg + 1'b1 : pos_reg;
        idx_next   = cmd.calc_phase ? idx_reg + CNT_W'(step) : idx_reg;
        phase_next = cmd.calc_phase ? total[PHASE_W-1:0] : phase_reg;
        tgt_next   = tgt_reg;
        if (cmd.finish)
        begin
            tgt_next = CNT_W'(idx_reg * CNT_W'(INTERP_FACTOR))
                     + CNT_W'(frac_prod[FW-1:PHASE_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            tgt_reg       <= '0;
            idx_reg       <= '0;
            phase_reg     <= '0;
            h0_re_reg     <= '0;
            h0_im_reg     <= '0;
            h1_re_reg     <= '0;
            h1_im_reg     <= '0;
            rail0_reg     <= '0;
            rail1_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            if (cmd.calc_phase)
            begin
                h1_re_reg <= h0_re_reg;
                h1_im_reg <= h0_im_reg;
                rail1_reg <= rail0_reg;
                h0_re_reg <= smp_re_reg;
                h0_im_reg <= smp_im_reg;
                rail0_reg <= rail_cur;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            smp_re_reg <= sample_re;
            smp_im_reg <= sample_im;
        end
        if (cmd.calc_err)
        begin
            err_reg <= err_next;
        end
        if (cmd.calc_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.finish)
        begin
            sym_re_reg <= ext_re[SYM_W-1:0];
            sym_im_reg <= ext_im[SYM_W-1:0];
            oerr_reg   <= err_reg;
            ophase_reg <= phase_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_re    = sym_re_reg;
    assign symbol_im    = sym_im_reg;
    assign timing_error = oerr_reg;
    assign phase_frac   = ophase_reg;

endmodule

`default_nettype wire
